// ----- hw/rtl/fmsw_pkg.sv -----
// Shared types, command codes and helpers for the FM shadow register writer.
`default_nettype none
package fmsw_pkg;

  localparam int SHADOW_DEPTH = 512;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [4:0] CMD_TL     = 5'd0;
  localparam logic [4:0] CMD_AR     = 5'd1;
  localparam logic [4:0] CMD_D1R    = 5'd2;
  localparam logic [4:0] CMD_D2R    = 5'd3;
  localparam logic [4:0] CMD_RR     = 5'd4;
  localparam logic [4:0] CMD_D1L    = 5'd5;
  localparam logic [4:0] CMD_DT     = 5'd6;
  localparam logic [4:0] CMD_MUL    = 5'd7;
  localparam logic [4:0] CMD_RS     = 5'd8;
  localparam logic [4:0] CMD_AM     = 5'd9;
  localparam logic [4:0] CMD_FMS    = 5'd10;
  localparam logic [4:0] CMD_AMS    = 5'd11;
  localparam logic [4:0] CMD_ALG    = 5'd12;
  localparam logic [4:0] CMD_FB     = 5'd13;
  localparam logic [4:0] CMD_LFO_EN = 5'd14;
  localparam logic [4:0] CMD_LFO_F  = 5'd15;
  localparam logic [4:0] CMD_FREQ   = 5'd16;
  localparam logic [4:0] CMD_KEY_ON = 5'd17;
  localparam logic [4:0] CMD_KEY_OF = 5'd18;
  localparam logic [4:0] CMD_RAW    = 5'd19;

  localparam logic [7:0] REG_LFO    = 8'h22;
  localparam logic [7:0] REG_KEY    = 8'h28;
  localparam logic [7:0] REG_DT_MUL = 8'h30;
  localparam logic [7:0] REG_TL     = 8'h40;
  localparam logic [7:0] REG_RS_AR  = 8'h50;
  localparam logic [7:0] REG_AM_D1R = 8'h60;
  localparam logic [7:0] REG_D2R    = 8'h70;
  localparam logic [7:0] REG_D1L_RR = 8'h80;
  localparam logic [7:0] REG_FNUM_L = 8'hA0;
  localparam logic [7:0] REG_FNUM_H = 8'hA4;
  localparam logic [7:0] REG_FB_ALG = 8'hB0;
  localparam logic [7:0] REG_PAN    = 8'hB4;

  typedef struct packed {
    logic [4:0]  command;
    logic [2:0]  channel;
    logic [1:0]  operator_index;
    logic [15:0] value;
    logic [7:0]  raw_address;
    logic        raw_port;
  } in_word_t;

  // one bus write for the back end: data = (shadow & keep) | bits
  typedef struct packed {
    logic       port;
    logic [7:0] addr;
    logic [7:0] keep;
    logic [7:0] bits;
    logic       last;
  } op_t;

  typedef struct packed {
    logic       bus_port;
    logic [7:0] bus_address;
    logic [7:0] bus_data;
    logic       last_write;
  } out_word_t;

  function automatic logic [7:0] clamp8(input logic [15:0] v, input logic [7:0] lim);
    return (v > {8'h00, lim}) ? lim : v[7:0];
  endfunction

  function automatic logic [1:0] slot_of(input logic [2:0] ch);
    logic [1:0] s;
    case (ch)
      3'd0, 3'd3, 3'd6: s = 2'd0;
      3'd1, 3'd4, 3'd7: s = 2'd1;
      default:          s = 2'd2;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fm_chip_shadow_register_writer.sv -----
// Top level: command front end, op queue, shadow back end, result queue.
// The back end does one bus write at a time (shadow read, then modify and
// write back, held while the result queue is full); set-frequency makes two.
// Reset: after rst_n the shadow memory is zeroed one entry per cycle, every one
// of its SHADOW_ENTRIES entries, with in_full held high until it finishes.
`default_nettype none
module fm_chip_shadow_register_writer #(
  parameter int SHADOW_ENTRIES = fmsw_pkg::SHADOW_DEPTH,
  parameter int QUEUE_DEPTH    = fmsw_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [4:0]  in_command,
  input  wire logic [2:0]  in_channel,
  input  wire logic [1:0]  in_operator_index,
  input  wire logic [15:0] in_value,
  input  wire logic [7:0]  in_raw_address,
  input  wire logic        in_raw_port,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_bus_port,
  output logic [7:0]       out_bus_address,
  output logic [7:0]       out_bus_data,
  output logic             out_last_write
);
  import fmsw_pkg::*;

  in_word_t  in_word;
  op_t       fr_op, bk_op;
  out_word_t bk_out, q_out;
  logic      clearing, op_push, op_full, op_empty, op_pop;
  logic      out_push, out_full;

  assign in_word.command        = in_command;
  assign in_word.channel        = in_channel;
  assign in_word.operator_index = in_operator_index;
  assign in_word.value          = in_value;
  assign in_word.raw_address    = in_raw_address;
  assign in_word.raw_port       = in_raw_port;

  fmsw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .op_push  (op_push),
    .op_word  (fr_op),
    .op_full  (op_full)
  );

  fmsw_fifo #(
    .Width ($bits(op_t)),
    .Depth (QUEUE_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (fr_op),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (bk_op),
    .empty (op_empty)
  );

  fmsw_back #(
    .SHADOW_ENTRIES (SHADOW_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .op_empty (op_empty),
    .op_word  (bk_op),
    .op_pop   (op_pop),
    .out_push (out_push),
    .out_word (bk_out),
    .out_full (out_full)
  );

  fmsw_fifo #(
    .Width ($bits(out_word_t)),
    .Depth (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (bk_out),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (q_out),
    .empty (out_empty)
  );

  assign out_bus_port    = q_out.bus_port;
  assign out_bus_address = q_out.bus_address;
  assign out_bus_data    = q_out.bus_data;
  assign out_last_write  = q_out.last_write;

`ifndef ASSERT_OFF
  a_no_out_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("result word pushed into full queue");

  a_no_op_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    op_push |-> !op_full) else $error("op pushed into full queue");

  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!out_push && !op_pop)) else $error("bus activity during shadow clear");

  a_first_write_is_fnum_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && !bk_out.last_write) |-> (bk_out.bus_address[7:2] == 6'b101001))
    else $error("non-final write outside frequency high registers");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/fmsw_fifo.sv -----
// Small synchronous word queue used between the stages.
`default_nettype none
module fmsw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slots_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fmsw_front.sv -----
// Front end: takes a command word, decodes it into one or two bus write ops (none for an unknown code).
`default_nettype none
module fmsw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clearing,
  input  wire logic              in_push,
  input  wire fmsw_pkg::in_word_t in_word,
  output logic                   in_full,
  output logic                   op_push,
  output fmsw_pkg::op_t          op_word,
  input  wire logic              op_full
);
  import fmsw_pkg::*;

  in_word_t   hold_r;
  logic       hold_v_r, hold_v_nxt;
  logic       phase_r, phase_nxt;
  logic       accept, done, cmd_ok, is_freq;
  logic       port;
  logic [1:0] slot;
  logic [7:0] opoff, slot8;
  logic [15:0] val;
  logic       bitv;
  logic [2:0] shift;
  logic [15:0] fshift;
  logic [10:0] fnum;
  logic [2:0] block;
  op_t        op;

  assign val   = hold_r.value;
  assign bitv  = |hold_r.value;
  assign port  = (hold_r.channel > 3'd2);
  assign slot  = slot_of(hold_r.channel);
  assign slot8 = {6'b0, slot};
  assign opoff = {4'b0, hold_r.operator_index, 2'b00} + slot8;

  // halvings needed to bring the frequency below 2048
  always_comb begin
    if (val[15])      shift = 3'd5;
    else if (val[14]) shift = 3'd4;
    else if (val[13]) shift = 3'd3;
    else if (val[12]) shift = 3'd2;
    else if (val[11]) shift = 3'd1;
    else              shift = 3'd0;
  end
  assign fshift = val >> shift;
  assign fnum   = fshift[10:0];
  assign block  = 3'd2 + shift;

  always_comb begin
    cmd_ok  = 1'b1;
    is_freq = 1'b0;
    op.port = port;
    op.addr = 8'h00;
    op.keep = 8'h00;
    op.bits = 8'h00;
    op.last = 1'b1;
    case (hold_r.command)
      CMD_TL: begin
        op.addr = REG_TL + opoff;     op.bits = clamp8(val, 8'h7F);
      end
      CMD_AR: begin
        op.addr = REG_RS_AR + opoff;  op.keep = 8'hE0; op.bits = clamp8(val, 8'h1F);
      end
      CMD_D1R: begin
        op.addr = REG_AM_D1R + opoff; op.keep = 8'h80; op.bits = clamp8(val, 8'h1F);
      end
      CMD_D2R: begin
        op.addr = REG_D2R + opoff;    op.bits = clamp8(val, 8'h1F);
      end
      CMD_RR: begin
        op.addr = REG_D1L_RR + opoff; op.keep = 8'hF0; op.bits = clamp8(val, 8'h0F);
      end
      CMD_D1L: begin
        op.addr = REG_D1L_RR + opoff; op.keep = 8'h0F; op.bits = clamp8(val, 8'h0F) << 4;
      end
      CMD_DT: begin
        op.addr = REG_DT_MUL + opoff; op.keep = 8'h0F; op.bits = clamp8(val, 8'h07) << 4;
      end
      CMD_MUL: begin
        op.addr = REG_DT_MUL + opoff; op.keep = 8'h70; op.bits = clamp8(val, 8'h0F);
      end
      CMD_RS: begin
        op.addr = REG_RS_AR + opoff;  op.keep = 8'h1F; op.bits = clamp8(val, 8'h03) << 6;
      end
      CMD_AM: begin
        op.addr = REG_AM_D1R + opoff; op.keep = 8'h7F; op.bits = {bitv, 7'b0};
      end
      CMD_FMS: begin
        op.addr = REG_PAN + slot8;    op.keep = 8'hF8; op.bits = clamp8(val, 8'h07);
      end
      CMD_AMS: begin
        // both speaker bits forced on
        op.addr = REG_PAN + slot8;    op.keep = 8'hC7;
        op.bits = (clamp8(val, 8'h03) << 4) | 8'hC0;
      end
      CMD_ALG: begin
        op.addr = REG_FB_ALG + slot8; op.keep = 8'hF8; op.bits = clamp8(val, 8'h07);
      end
      CMD_FB: begin
        op.addr = REG_FB_ALG + slot8; op.keep = 8'hC7; op.bits = clamp8(val, 8'h07) << 3;
      end
      CMD_LFO_EN: begin
        op.port = 1'b0; op.addr = REG_LFO; op.keep = 8'hF7; op.bits = {4'b0, bitv, 3'b0};
      end
      CMD_LFO_F: begin
        op.port = 1'b0; op.addr = REG_LFO; op.keep = 8'hF8; op.bits = clamp8(val, 8'h07);
      end
      CMD_FREQ: begin
        is_freq = 1'b1;
        if (phase_r) begin
          op.addr = REG_FNUM_L + slot8; op.bits = fnum[7:0];
        end else begin
          op.addr = REG_FNUM_H + slot8; op.bits = {2'b00, block, fnum[10:8]};
          op.last = 1'b0;
        end
      end
      CMD_KEY_ON: begin
        op.port = 1'b0; op.addr = REG_KEY; op.bits = {5'b11110, port, slot};
      end
      CMD_KEY_OF: begin
        op.port = 1'b0; op.addr = REG_KEY; op.bits = {5'b00000, port, slot};
      end
      CMD_RAW: begin
        op.port = hold_r.raw_port; op.addr = hold_r.raw_address; op.bits = val[7:0];
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  assign op_word = op;
  assign op_push = hold_v_r && cmd_ok && !op_full;
  // unknown codes are dropped without a write
  assign done    = hold_v_r && (!cmd_ok || (!op_full && (!is_freq || phase_r)));
  assign in_full = clearing || (hold_v_r && !done);
  assign accept  = in_push && !in_full;

  always_comb begin
    hold_v_nxt = hold_v_r;
    phase_nxt  = phase_r;
    if (done) begin
      hold_v_nxt = 1'b0;
      phase_nxt  = 1'b0;
    end else if (op_push && is_freq) begin
      phase_nxt = 1'b1;
    end
    if (accept) begin
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_word;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fmsw_back.sv -----
// Back end: shadow memory (zeroed after reset), read-modify-write of each op, bus word out.
`default_nettype none
module fmsw_back #(
  parameter int SHADOW_ENTRIES = fmsw_pkg::SHADOW_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  output logic                clearing,
  input  wire logic           op_empty,
  input  wire fmsw_pkg::op_t  op_word,
  output logic                op_pop,
  output logic                out_push,
  output fmsw_pkg::out_word_t out_word,
  input  wire logic           out_full
);
  import fmsw_pkg::*;

  localparam int ShAw = $clog2(SHADOW_ENTRIES);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_MOD   = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [ShAw-1:0] clr_cnt_r, clr_cnt_nxt;
  op_t             op_r;
  logic [7:0]      shadow_mem [SHADOW_ENTRIES];
  logic [7:0]      rdata_r;
  logic            rd_en, we;
  logic [ShAw-1:0] rd_idx, wr_idx;
  logic [7:0]      wr_data, mod_data;

  assign clearing = (state_r == ST_CLEAR);
  assign mod_data = (rdata_r & op_r.keep) | op_r.bits;
  assign rd_idx   = ShAw'({op_word.port, op_word.addr});

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    op_pop      = 1'b0;
    rd_en       = 1'b0;
    we          = 1'b0;
    out_push    = 1'b0;
    wr_idx      = ShAw'({op_r.port, op_r.addr});
    wr_data     = mod_data;
    case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        wr_idx      = clr_cnt_r;
        wr_data     = 8'h00;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ShAw'(SHADOW_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!op_empty) begin
          op_pop    = 1'b1;
          rd_en     = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!out_full) begin
          we        = 1'b1;
          out_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_word.bus_port    = op_r.port;
  assign out_word.bus_address = op_r.addr;
  assign out_word.bus_data    = mod_data;
  assign out_word.last_write  = op_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      op_r <= op_word;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      shadow_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= shadow_mem[rd_idx];
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_fm_chip_shadow_register_writer.sv -----
// Testbench for the FM chip shadow register writer: shadow-model scoreboard and queue drivers.
`default_nettype none
module tb_fm_chip_shadow_register_writer;
  import fmsw_pkg::*;

  class shadow_model;
    logic [7:0] shadow[512];
    out_word_t  pending_writes[$];
    int         fail_count;
    int         words_checked;

    function new();
      foreach (shadow[i]) shadow[i] = 8'h00;
      fail_count    = 0;
      words_checked = 0;
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function logic [7:0] sat(logic [15:0] v, logic [7:0] lim);
      if (v > 16'(lim)) return lim;
      return v[7:0];
    endfunction

    function void post(logic port, logic [7:0] addr, logic [7:0] data, logic last);
      out_word_t w;
      shadow[{port, addr}] = data;
      w.bus_port    = port;
      w.bus_address = addr;
      w.bus_data    = data;
      w.last_write  = last;
      pending_writes.push_back(w);
    endfunction

    // read-modify-write of one field against the shadow copy
    function void rmw(logic port, logic [7:0] addr, logic [7:0] keep, logic [7:0] bits);
      post(port, addr, (shadow[{port, addr}] & keep) | bits, 1'b1);
    endfunction

    function void note_command(in_word_t c);
      logic        port;
      logic [1:0]  slot;
      logic [7:0]  opaddr;
      logic [7:0]  chaddr;
      logic [15:0] f;
      logic [2:0]  blk;
      logic        nz;
      port   = (c.channel > 3'd2);
      slot   = 2'(c.channel % 3);
      opaddr = 8'(4 * c.operator_index) + 8'(slot);
      chaddr = 8'(slot);
      nz     = (c.value != 16'd0);
      case (c.command)
        CMD_TL:     rmw(port, REG_TL + opaddr,     8'h00, sat(c.value, 8'h7F));
        CMD_AR:     rmw(port, REG_RS_AR + opaddr,  8'hE0, sat(c.value, 8'h1F));
        CMD_D1R:    rmw(port, REG_AM_D1R + opaddr, 8'h80, sat(c.value, 8'h1F));
        CMD_D2R:    rmw(port, REG_D2R + opaddr,    8'h00, sat(c.value, 8'h1F));
        CMD_RR:     rmw(port, REG_D1L_RR + opaddr, 8'hF0, sat(c.value, 8'h0F));
        CMD_D1L:    rmw(port, REG_D1L_RR + opaddr, 8'h0F, sat(c.value, 8'h0F) << 4);
        CMD_DT:     rmw(port, REG_DT_MUL + opaddr, 8'h0F, sat(c.value, 8'h07) << 4);
        CMD_MUL:    rmw(port, REG_DT_MUL + opaddr, 8'h70, sat(c.value, 8'h0F));
        CMD_RS:     rmw(port, REG_RS_AR + opaddr,  8'h1F, sat(c.value, 8'h03) << 6);
        CMD_AM:     rmw(port, REG_AM_D1R + opaddr, 8'h7F, {nz, 7'd0});
        CMD_FMS:    rmw(port, REG_PAN + chaddr,    8'hF8, sat(c.value, 8'h07));
        // AMS also forces both speaker enables on
        CMD_AMS:    rmw(port, REG_PAN + chaddr,    8'hC7,
                        (sat(c.value, 8'h03) << 4) | 8'hC0);
        CMD_ALG:    rmw(port, REG_FB_ALG + chaddr, 8'hF8, sat(c.value, 8'h07));
        CMD_FB:     rmw(port, REG_FB_ALG + chaddr, 8'hC7, sat(c.value, 8'h07) << 3);
        CMD_LFO_EN: rmw(1'b0, REG_LFO, 8'hF7, {4'd0, nz, 3'd0});
        CMD_LFO_F:  rmw(1'b0, REG_LFO, 8'hF8, sat(c.value, 8'h07));
        CMD_FREQ: begin
          f   = c.value;
          blk = 3'd2;
          while (f >= 16'd2048) begin
            f   = f >> 1;
            blk = blk + 3'd1;
          end
          post(port, REG_FNUM_H + chaddr, {2'b00, blk, f[10:8]}, 1'b0);
          post(port, REG_FNUM_L + chaddr, f[7:0], 1'b1);
        end
        CMD_KEY_ON: post(1'b0, REG_KEY, {5'b11110, port, slot}, 1'b1);
        CMD_KEY_OF: post(1'b0, REG_KEY, {5'b00000, port, slot}, 1'b1);
        CMD_RAW:    post(c.raw_port, c.raw_address, c.value[7:0], 1'b1);
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("  error @%0t: %s got %0h want %0h", $time, what, got, want);
      fail_count++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending_writes.size() == 0) begin
        report("word with nothing pending, address", got.bus_address, 0);
        return;
      end
      want = pending_writes.pop_front();
      words_checked++;
      if (got.bus_port !== want.bus_port)
        report("bus_port", got.bus_port, want.bus_port);
      if (got.bus_address !== want.bus_address)
        report("bus_address", got.bus_address, want.bus_address);
      if (got.bus_data !== want.bus_data)
        report("bus_data", got.bus_data, want.bus_data);
      if (got.last_write !== want.last_write)
        report("last_write", got.last_write, want.last_write);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [4:0]  in_command;
  logic [2:0]  in_channel;
  logic [1:0]  in_operator_index;
  logic [15:0] in_value;
  logic [7:0]  in_raw_address;
  logic        in_raw_port;
  logic        out_empty;
  logic        out_pop;
  logic        out_bus_port;
  logic [7:0]  out_bus_address;
  logic [7:0]  out_bus_data;
  logic        out_last_write;

  shadow_model sb;
  bit          burst;
  int          commands_sent;
  int          ignored_sent;

  fm_chip_shadow_register_writer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_channel        (in_channel),
    .in_operator_index (in_operator_index),
    .in_value          (in_value),
    .in_raw_address    (in_raw_address),
    .in_raw_port       (in_raw_port),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_bus_port      (out_bus_port),
    .out_bus_address   (out_bus_address),
    .out_bus_data      (out_bus_data),
    .out_last_write    (out_last_write)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_command(input in_word_t c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_command        <= c.command;
    in_channel        <= c.channel;
    in_operator_index <= c.operator_index;
    in_value          <= c.value;
    in_raw_address    <= c.raw_address;
    in_raw_port       <= c.raw_port;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.note_command(c);
    if (c.command > CMD_RAW) ignored_sent++;
    else commands_sent++;
  endtask

  // hold the sender off until every pending bus word has come out
  task automatic drain_wait();
    in_push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [15:0] pick_value();
    logic [15:0] edges[9];
    edges = '{16'h0000, 16'h0001, 16'h0007, 16'h0008, 16'h007F, 16'h0080,
              16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom);
      default: return edges[$urandom_range(0, 8)];
    endcase
  endfunction

  // result side: random pop stalls, check each word as it is taken
  initial begin : result_side
    int        stall;
    out_word_t got;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      got.bus_port    = out_bus_port;
      got.bus_address = out_bus_address;
      got.bus_data    = out_bus_data;
      got.last_write  = out_last_write;
      sb.check_word(got);
    end
  end

  initial begin : stimulus
    in_word_t c;
    sb                = new();
    burst             = 1'b0;
    commands_sent     = 0;
    ignored_sent      = 0;
    rst_n             <= 1'b0;
    in_push           <= 1'b0;
    in_command        <= '0;
    in_channel        <= '0;
    in_operator_index <= '0;
    in_value          <= '0;
    in_raw_address    <= '0;
    in_raw_port       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // every command once, alternating zero and full-scale values
    for (int k = 0; k <= 19; k++) begin
      c.command        = 5'(k);
      c.channel        = 3'(k % 8);
      c.operator_index = 2'(k % 4);
      c.value          = (k % 2) ? 16'hFFFF : 16'h0000;
      c.raw_address    = 8'hFF;
      c.raw_port       = 1'b1;
      send_command(c);
    end
    // frequency just below and at the halving threshold, channels six and seven
    c = '{CMD_FREQ, 3'd7, 2'd0, 16'd2047, 8'h00, 1'b0};
    send_command(c);
    c = '{CMD_FREQ, 3'd6, 2'd3, 16'd2048, 8'h00, 1'b0};
    send_command(c);
    c = '{CMD_KEY_ON, 3'd7, 2'd0, 16'h0001, 8'h00, 1'b0};
    send_command(c);
    c = '{5'd31, 3'd2, 2'd1, 16'h1234, 8'h28, 1'b1};
    send_command(c);
    c = '{CMD_RAW, 3'd0, 2'd0, 16'hAA00, 8'h00, 1'b0};
    send_command(c);
    drain_wait();

    for (int i = 0; i < 1325; i++) begin
      burst = (i % 300) >= 240;
      if ($urandom_range(0, 9) == 0) c.command = 5'($urandom_range(20, 31));
      else c.command = 5'($urandom_range(0, 19));
      c.channel        = 3'($urandom_range(0, 7));
      c.operator_index = 2'($urandom_range(0, 3));
      c.value          = pick_value();
      c.raw_address    = 8'($urandom_range(0, 255));
      c.raw_port       = 1'($urandom_range(0, 1));
      send_command(c);
      if (i == 700) drain_wait();
    end
    burst = 1'b0;
    drain_wait();
    repeat (10) @(posedge clk);

    $display("run: %0d commands (%0d ignored codes) over all fields and channels 0-7,",
             commands_sent, ignored_sent);
    $display("     %0d bus words checked against the shadow model with random stalls",
             sb.words_checked);
    if (sb.fail_count == 0) begin
      $display("fm_chip_shadow_register_writer: match");
    end else begin
      $display("fm_chip_shadow_register_writer: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout: %0d words still pending", sb.pending());
    $display("fm_chip_shadow_register_writer: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
